// ===== design/nutb_pkg.sv =====
// nutb_pkg: shared types, constants and the cordic angle table for the
// nearest unvisited target bearing block. No dependencies.
package nutb_pkg;

  localparam int MAX_TARGETS_DEF = 32;
  localparam int COORD_BITS_DEF  = 20;

  localparam int SLOT_W     = 5;
  localparam int COUNT_W    = 6;
  localparam int RADIUS_W   = 20;
  localparam int R2_W       = 2 * RADIUS_W;
  localparam int ANG_W      = 16;
  localparam int MASK_W     = 32;
  localparam int DIST_W     = 21;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_SHIFT = 26;

  localparam logic [DIST_W-1:0]     DIST_SAT     = 21'd1482911;
  localparam logic [ANG_W-1:0]      ANG_PI       = 16'd32768;
  localparam logic [RADIUS_W-1:0]   RADIUS_RESET = 20'd256;

  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FETCH,
    ST_PREP,
    ST_INIT,
    ST_ARITH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic fetch;
    logic init;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic issue_done;
    logic pipe_empty;
    logic arith_done;
    logic out_free;
  } ctrl_sts_t;

  function automatic logic [ANG_W-1:0] cordic_angle(input logic [3:0] i);
    logic [ANG_W-1:0] a;
    case (i)
      4'd0:    a = 16'd8192;
      4'd1:    a = 16'd4836;
      4'd2:    a = 16'd2555;
      4'd3:    a = 16'd1297;
      4'd4:    a = 16'd651;
      4'd5:    a = 16'd326;
      4'd6:    a = 16'd163;
      4'd7:    a = 16'd81;
      4'd8:    a = 16'd41;
      4'd9:    a = 16'd20;
      4'd10:   a = 16'd10;
      4'd11:   a = 16'd5;
      4'd12:   a = 16'd3;
      4'd13:   a = 16'd1;
      4'd14:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== design/nutb_ctrl.sv =====
// nutb_ctrl: sequencer for loads and queries; drives datapath commands.
// Depends on nutb_pkg.
module nutb_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  command,
  output logic                  in_stall,
  output nutb_pkg::ctrl_cmd_t   cmd,
  input  nutb_pkg::ctrl_sts_t   sts
);
  import nutb_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && command == CMD_QUERY) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (sts.issue_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.pipe_empty) state_next = ST_FETCH;
      end
      ST_FETCH: state_next = ST_PREP;
      ST_PREP:  state_next = ST_INIT;
      ST_INIT:  state_next = ST_ARITH;
      ST_ARITH: begin
        if (sts.arith_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall  = 1'b0;
        cmd.load  = in_valid && command == CMD_LOAD;
        cmd.start = in_valid && command == CMD_QUERY;
      end
      ST_WALK:  cmd.issue = 1'b1;
      ST_FETCH: cmd.fetch = 1'b1;
      ST_INIT:  cmd.init  = 1'b1;
      ST_ARITH: cmd.step  = 1'b1;
      ST_DONE:  cmd.emit  = sts.out_free;
      default: ;
    endcase
  end

endmodule

// ===== design/nutb_datapath.sv =====
// nutb_datapath: target table, distance walk pipeline, square root and cordic,
// config registers and result register. Depends on nutb_pkg.
module nutb_datapath #(
  parameter int MAX_TARGETS = nutb_pkg::MAX_TARGETS_DEF,
  parameter int COORD_BITS  = nutb_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  nutb_pkg::ctrl_cmd_t                 cmd,
  output nutb_pkg::ctrl_sts_t                 sts,
  input  logic                                cfg_valid,
  input  logic [nutb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nutb_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [nutb_pkg::SLOT_W-1:0]         slot,
  input  logic signed [COORD_BITS-1:0]        target_x,
  input  logic signed [COORD_BITS-1:0]        target_y,
  input  logic signed [COORD_BITS-1:0]        agent_x,
  input  logic signed [COORD_BITS-1:0]        agent_y,
  input  logic signed [nutb_pkg::ANG_W-1:0]   heading,
  input  logic [nutb_pkg::MASK_W-1:0]         visited_mask,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic                                found,
  output logic [nutb_pkg::SLOT_W-1:0]         nearest_slot,
  output logic [nutb_pkg::DIST_W-1:0]         nearest_distance,
  output logic signed [nutb_pkg::ANG_W-1:0]   bearing,
  output logic                                at_target,
  output logic [nutb_pkg::SLOT_W-1:0]         current_slot
);
  import nutb_pkg::*;

  localparam int IW    = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CNT_W = $clog2(MAX_TARGETS + 1);
  localparam int DW    = COORD_BITS + 1;
  localparam int SQ_W  = 2 * COORD_BITS + 1;
  localparam int D2_W  = 2 * COORD_BITS + 2;
  localparam int CMP_W = (D2_W > R2_W) ? D2_W : R2_W;
  localparam int RW    = COORD_BITS + 1;
  localparam int STEPS = (RW > CORDIC_STEPS) ? RW : CORDIC_STEPS;
  localparam int STEP_W = $clog2(STEPS);
  localparam int XW    = COORD_BITS + 1 + CORDIC_SHIFT + 2;

  // config registers
  logic [COUNT_W-1:0]  count;
  logic [RADIUS_W-1:0] radius;
  logic [R2_W-1:0]     r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_COUNT)  count  <= cfg_data[COUNT_W-1:0];
      if (cfg_index == REG_RADIUS) radius <= cfg_data[RADIUS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    r2 <= R2_W'(radius) * R2_W'(radius);
  end

  // query latch
  logic signed [COORD_BITS-1:0] ax, ay;
  logic signed [ANG_W-1:0]      head;
  logic [63:0]                  mask;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ax   <= agent_x;
      ay   <= agent_y;
      head <= heading;
      mask <= 64'(visited_mask);
    end
  end

  // walk counter
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] n_lim;
  logic [7:0]       count_ext;
  logic             issue_ok;

  assign count_ext = 8'(count);
  assign n_lim     = (count_ext > 8'(MAX_TARGETS)) ? CNT_W'(MAX_TARGETS) : CNT_W'(count);
  assign issue_ok  = cnt < n_lim;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cnt <= '0;
    end else if (cmd.issue && issue_ok) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  // target table
  logic signed [COORD_BITS-1:0] mem_x [MAX_TARGETS];
  logic signed [COORD_BITS-1:0] mem_y [MAX_TARGETS];
  logic signed [COORD_BITS-1:0] rd_x, rd_y;
  logic [7:0]                   slot_ext;
  logic                         we;
  logic [IW-1:0]                wa, ra;
  logic [IW-1:0]                best;

  assign slot_ext = 8'(slot);
  assign we       = cmd.load && (slot_ext < 8'(MAX_TARGETS));
  assign wa       = slot_ext[IW-1:0];
  assign ra       = cmd.fetch ? best : cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_x[wa] <= target_x;
      mem_y[wa] <= target_y;
    end
    rd_x <= mem_x[ra];
    rd_y <= mem_y[ra];
  end

  // distance pipeline: read, difference, squares, sum
  logic                    s1_valid, s2_valid, s3_valid, s4_valid;
  logic [IW-1:0]           s1_idx, s2_idx, s3_idx, s4_idx;
  logic signed [DW-1:0]    dx, dy;
  logic signed [2*DW-1:0]  px, py;
  logic [SQ_W-1:0]         sqx, sqy;
  logic [D2_W-1:0]         d2;

  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue && issue_ok;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx <= ra;
    s2_idx <= s1_idx;
    s3_idx <= s2_idx;
    s4_idx <= s3_idx;
    dx     <= DW'(rd_x) - DW'(ax);
    dy     <= DW'(rd_y) - DW'(ay);
    sqx    <= px[SQ_W-1:0];
    sqy    <= py[SQ_W-1:0];
    d2     <= D2_W'(sqx) + D2_W'(sqy);
  end

  // best and capture tracking
  logic            best_found, at;
  logic [IW-1:0]   cur;
  logic [D2_W-1:0] best_d2;
  logic            masked;

  assign masked = mask[s4_idx];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      best_found <= 1'b0;
      at         <= 1'b0;
      best       <= '0;
      cur        <= '0;
    end else if (s4_valid) begin
      if (!at && CMP_W'(d2) < CMP_W'(r2)) begin
        at  <= 1'b1;
        cur <= s4_idx;
      end
      if (!masked && (!best_found || d2 < best_d2)) begin
        best_found <= 1'b1;
        best       <= s4_idx;
        best_d2    <= d2;
      end
    end
  end

  // shared step counter for square root and cordic
  logic [STEP_W-1:0] step;

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      step <= '0;
    end else if (cmd.step) begin
      step <= step + STEP_W'(1);
    end
  end

  // square root, two radicand bits per step
  logic [D2_W-1:0] v;
  logic [RW+1:0]   rem, rem_sh, trial;
  logic [RW-1:0]   root;

  assign rem_sh = {rem[RW-1:0], v[D2_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      v    <= best_d2;
      rem  <= '0;
      root <= '0;
    end else if (cmd.step && step < STEP_W'(RW)) begin
      v <= v << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  // cordic vectoring
  logic signed [XW-1:0]  cx, cy, xs, ys, dx_w, dy_w;
  logic [ANG_W-1:0]      cz;

  assign dx_w = XW'(dx) <<< CORDIC_SHIFT;
  assign dy_w = XW'(dy) <<< CORDIC_SHIFT;
  assign xs   = cx >>> step[3:0];
  assign ys   = cy >>> step[3:0];

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      if (dx < 0) begin
        cx <= -dx_w;
        cy <= -dy_w;
        cz <= ANG_PI;
      end else begin
        cx <= dx_w;
        cy <= dy_w;
        cz <= '0;
      end
    end else if (cmd.step && step < STEP_W'(CORDIC_STEPS)) begin
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + cordic_angle(step[3:0]);
      end else if (cy < 0) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - cordic_angle(step[3:0]);
      end
    end
  end

  // result register
  logic [RW:0]         rnd;
  logic [DIST_W-1:0]   dist_out;

  assign rnd      = (RW+1)'(root) + (RW+1)'((RW+2)'(rem) > (RW+2)'(root));
  assign dist_out = (!best_found || 33'(rnd) > 33'(DIST_SAT)) ? DIST_SAT : DIST_W'(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      found            <= best_found;
      nearest_slot     <= SLOT_W'(best);
      nearest_distance <= dist_out;
      bearing          <= cz - head;
      at_target        <= at;
      current_slot     <= SLOT_W'(cur);
    end
  end

  assign sts.issue_done = !issue_ok;
  assign sts.pipe_empty = !(s1_valid || s2_valid || s3_valid || s4_valid);
  assign sts.arith_done = step == STEP_W'(STEPS - 1);
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

// ===== design/nearest_unvisited_target_bearing.sv =====
// nearest_unvisited_target_bearing: top level, joins sequencer and datapath.
// Depends on nutb_pkg, nutb_ctrl, nutb_datapath.
//
//  channel | signals                         | beat when
//  in      | in_valid, in_stall, fields      | in_valid && !in_stall
//  out     | out_valid, out_stall, fields    | out_valid && !out_stall
//  cfg     | cfg_valid, cfg_ready, idx, data | cfg_valid && cfg_ready
//
// a load writes one table slot; a query walks slots 0 to n-1 for a count of n
// (one slot per cycle through the table read port, a four stage drain, then
// the square root of COORD_BITS+1 steps beside the cordic; the longer sets the tail)
// reset clears control state, config and valid flags; the table holds garbage until loaded
// a finished result waits in the output register while out_stall is high
module nearest_unvisited_target_bearing #(
  parameter int MAX_TARGETS = nutb_pkg::MAX_TARGETS_DEF,
  parameter int COORD_BITS  = nutb_pkg::COORD_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [nutb_pkg::SLOT_W-1:0]         slot,
  input  logic signed [COORD_BITS-1:0]        target_x,
  input  logic signed [COORD_BITS-1:0]        target_y,
  input  logic signed [COORD_BITS-1:0]        agent_x,
  input  logic signed [COORD_BITS-1:0]        agent_y,
  input  logic signed [nutb_pkg::ANG_W-1:0]   heading,
  input  logic [nutb_pkg::MASK_W-1:0]         visited_mask,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                found,
  output logic [nutb_pkg::SLOT_W-1:0]         nearest_slot,
  output logic [nutb_pkg::DIST_W-1:0]         nearest_distance,
  output logic signed [nutb_pkg::ANG_W-1:0]   bearing,
  output logic                                at_target,
  output logic [nutb_pkg::SLOT_W-1:0]         current_slot,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [nutb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [nutb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import nutb_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  nutb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .command  (command),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  nutb_datapath #(
    .MAX_TARGETS (MAX_TARGETS),
    .COORD_BITS  (COORD_BITS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .slot             (slot),
    .target_x         (target_x),
    .target_y         (target_y),
    .agent_x          (agent_x),
    .agent_y          (agent_y),
    .heading          (heading),
    .visited_mask     (visited_mask),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .found            (found),
    .nearest_slot     (nearest_slot),
    .nearest_distance (nearest_distance),
    .bearing          (bearing),
    .at_target        (at_target),
    .current_slot     (current_slot)
  );

  // a query beat leaves the sequencer busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command == CMD_QUERY |=> in_stall)
    else $error("input not stalled after query beat");

  // never overwrite a result that is still held
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  a_no_found: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> nearest_distance == DIST_SAT && nearest_slot == '0)
    else $error("empty search result not saturated");

  a_no_capture: assert property (@(posedge clk) disable iff (rst)
    out_valid && !at_target |-> current_slot == '0)
    else $error("current slot set without capture");

endmodule
